>>> sv/fam_pkg.sv
`default_nettype none

package fam_pkg;

    // Motion modes.
    localparam logic [2:0] MODE_STOP    = 3'd0;
    localparam logic [2:0] MODE_REVERSE = 3'd1;
    localparam logic [2:0] MODE_FORWARD = 3'd2;
    localparam logic [2:0] MODE_NEXT    = 3'd3;
    localparam logic [2:0] MODE_PREV    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IR_FULL_LEVEL      = 2'd0;
    localparam logic [1:0] CFG_SINGLE_STEP_FRAMES = 2'd1;
    localparam logic [1:0] CFG_MULTI_STEP_FRAMES  = 2'd2;

    // Configuration reset values.
    localparam logic [6:0] IR_FULL_RESET       = 7'd100;
    localparam logic [3:0] SINGLE_FRAMES_RESET = 4'd1;
    localparam logic [3:0] MULTI_FRAMES_RESET  = 4'd3;

    // Integrator start value and the history pattern that marks a frame.
    localparam logic [6:0] IR_START      = 7'd50;
    localparam logic [7:0] FRAME_PATTERN = 8'h0f;

    // Command characters.
    localparam logic [7:0] CHR_A_LO = 8'h61;
    localparam logic [7:0] CHR_A_UP = 8'h41;
    localparam logic [7:0] CHR_B_LO = 8'h62;
    localparam logic [7:0] CHR_B_UP = 8'h42;
    localparam logic [7:0] CHR_N_LO = 8'h6e;
    localparam logic [7:0] CHR_N_UP = 8'h4e;
    localparam logic [7:0] CHR_P_LO = 8'h70;
    localparam logic [7:0] CHR_P_UP = 8'h50;
    localparam logic [7:0] CHR_F_LO = 8'h66;
    localparam logic [7:0] CHR_F_UP = 8'h46;
    localparam logic [7:0] CHR_R_LO = 8'h72;
    localparam logic [7:0] CHR_R_UP = 8'h52;
    localparam logic [7:0] CHR_S_LO = 8'h73;
    localparam logic [7:0] CHR_S_UP = 8'h53;
    localparam logic [7:0] CHR_X_LO = 8'h78;
    localparam logic [7:0] CHR_X_UP = 8'h58;
    localparam logic [7:0] CHR_L_LO = 8'h6c;
    localparam logic [7:0] CHR_L_UP = 8'h4c;
    localparam logic [7:0] CHR_C_LO = 8'h63;
    localparam logic [7:0] CHR_C_UP = 8'h43;
    localparam logic [7:0] CHR_LF   = 8'h0a;
    localparam logic [7:0] CHR_CR   = 8'h0d;

    typedef struct packed {
        logic [6:0] ir_full_level;
        logic [3:0] single_step_frames;
        logic [3:0] multi_step_frames;
    } fam_cfg_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [7:0] cmd_byte;
        logic       ir_level;
    } fam_in_t;

    typedef struct packed {
        logic       motor_forward;
        logic       motor_reverse;
        logic       lamp_on;
        logic       shutter_pulse;
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       command_error;
        logic       ir_indicator;
        logic       frame_mark;
    } fam_out_t;

endpackage

`default_nettype wire

>>> sv/fam_core.sv
`default_nettype none

module fam_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step_en,
    input  wire fam_pkg::fam_cfg_t cfg,
    input  wire fam_pkg::fam_in_t  item,
    output fam_pkg::fam_out_t   result
);
    import fam_pkg::*;

    logic [2:0] mode_reg, mode_next, mode_cmd;
    logic [3:0] frames_reg, frames_next, frames_cmd;
    logic [6:0] integ_reg, integ_next;
    logic [7:0] hist_reg, hist_next, hist_low;
    logic       lamp_reg, lamp_next;
    logic       shutter;
    logic       err;
    logic       mark;

    always_comb begin
        mode_cmd   = mode_reg;
        frames_cmd = frames_reg;
        lamp_next  = lamp_reg;
        shutter    = 1'b0;
        err        = 1'b0;

        if (item.cmd_valid) begin
            unique case (item.cmd_byte) inside
                CHR_A_LO, CHR_A_UP: begin
                    mode_cmd   = MODE_NEXT;
                    frames_cmd = cfg.single_step_frames;
                end
                CHR_B_LO, CHR_B_UP: begin
                    mode_cmd   = MODE_PREV;
                    frames_cmd = cfg.single_step_frames;
                end
                CHR_N_LO, CHR_N_UP: begin
                    mode_cmd   = MODE_NEXT;
                    frames_cmd = cfg.multi_step_frames;
                end
                CHR_P_LO, CHR_P_UP: begin
                    mode_cmd   = MODE_PREV;
                    frames_cmd = cfg.multi_step_frames;
                end
                CHR_F_LO, CHR_F_UP: mode_cmd = MODE_FORWARD;
                CHR_R_LO, CHR_R_UP: mode_cmd = MODE_REVERSE;
                CHR_S_LO, CHR_S_UP: mode_cmd = MODE_STOP;
                CHR_X_LO, CHR_X_UP: begin
                    mode_cmd  = MODE_STOP;
                    lamp_next = 1'b0;
                end
                CHR_L_LO:           lamp_next = 1'b1;
                CHR_L_UP:           lamp_next = 1'b0;
                CHR_C_LO, CHR_C_UP: shutter = 1'b1;
                CHR_LF, CHR_CR:     ;
                default:            err = 1'b1;
            endcase
        end

        // The integrator walks down while the beam is seen and up to the
        // full level otherwise; a value above the full level snaps to it.
        if (item.ir_level) begin
            integ_next = (integ_reg != 7'd0) ? integ_reg - 7'd1 : integ_reg;
        end else if (integ_reg < cfg.ir_full_level) begin
            integ_next = integ_reg + 7'd1;
        end else begin
            integ_next = cfg.ir_full_level;
        end

        // Both rails can shift in the same tick when the full level is zero.
        hist_low  = (integ_next == 7'd0) ? {hist_reg[6:0], 1'b0} : hist_reg;
        hist_next = (integ_next == cfg.ir_full_level) ? {hist_low[6:0], 1'b1}
                                                      : hist_low;
        mark = (hist_next == FRAME_PATTERN);

        mode_next   = mode_cmd;
        frames_next = frames_cmd;
        if (mark && (mode_cmd == MODE_NEXT || mode_cmd == MODE_PREV)) begin
            if (frames_cmd <= 4'd1) begin
                frames_next = 4'd0;
                mode_next   = MODE_STOP;
            end else begin
                frames_next = frames_cmd - 4'd1;
            end
        end

        result.motor_forward = (mode_next == MODE_FORWARD) || (mode_next == MODE_NEXT);
        result.motor_reverse = (mode_next == MODE_REVERSE) || (mode_next == MODE_PREV);
        result.lamp_on       = lamp_next;
        result.shutter_pulse = shutter;
        result.echo_valid    = item.cmd_valid;
        result.echo_byte     = item.cmd_valid ? item.cmd_byte : 8'd0;
        result.command_error = err;
        result.ir_indicator  = item.ir_level;
        result.frame_mark    = mark;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_STOP;
            frames_reg <= 4'd0;
            integ_reg  <= IR_START;
            hist_reg   <= 8'd0;
            lamp_reg   <= 1'b0;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            frames_reg <= frames_next;
            integ_reg  <= integ_next;
            hist_reg   <= hist_next;
            lamp_reg   <= lamp_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/frame_advance_motor_controller.sv
// Output: each result is registered and reaches the master side from the result register.
// Throughput: one control tick per cycle while m_tready stays high; the state update is a
// single pass of compares, increments and shifts ahead of the result register.
// Stalls: while a result waits, the skid register takes one more transfer; s_tready then
// stays low until m_tready takes the waiting result and the skid entry moves up.
// Reset: synchronous, active low on aresetn; clears buffers, motion state and registers.
`default_nettype none

module frame_advance_motor_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input ticks.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] cmd_byte, [8] ir_level, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] cmd_valid

    // Results.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0] m_tdata,  // [0] motor_forward, [1] motor_reverse, [2] lamp_on,
                                  // [3] shutter_pulse, [11:4] echo_byte,
                                  // [12] command_error, [13] ir_indicator,
                                  // [14] frame_mark, [15] zero
    output logic [0:0]  m_tuser,  // [0] echo_valid

    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);
    import fam_pkg::*;

    fam_cfg_t   cfg_reg, cfg_next;
    fam_in_t    item;
    fam_out_t   result;
    logic       accept;
    logic [15:0] res_data;
    logic [0:0]  res_user;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic [0:0]  out_user_reg, out_user_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [15:0] skid_data_reg, skid_data_next;
    logic [0:0]  skid_user_reg, skid_user_next;

    // Register writes are always taken; an index beyond the list is dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IR_FULL_LEVEL:      cfg_next.ir_full_level      = cfg_data;
                CFG_SINGLE_STEP_FRAMES: cfg_next.single_step_frames = cfg_data[3:0];
                CFG_MULTI_STEP_FRAMES:  cfg_next.multi_step_frames  = cfg_data[3:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ir_full_level      <= IR_FULL_RESET;
            cfg_reg.single_step_frames <= SINGLE_FRAMES_RESET;
            cfg_reg.multi_step_frames  <= MULTI_FRAMES_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The input side stalls only while the skid register is occupied.
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign item.cmd_valid = s_tuser[0];
    assign item.cmd_byte  = s_tdata[7:0];
    assign item.ir_level  = s_tdata[8];

    // The controller state advances once for every input transfer.
    fam_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (accept),
        .cfg     (cfg_reg),
        .item    (item),
        .result  (result)
    );

    assign res_data = {1'b0, result.frame_mark, result.ir_indicator, result.command_error,
                       result.echo_byte, result.shutter_pulse, result.lamp_on,
                       result.motor_reverse, result.motor_forward};
    assign res_user = result.echo_valid;

    // The result register drains first; the skid register catches a result
    // that arrives while the result register is stalled.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_user_next  = skid_user_reg;

        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_user_next   = skid_user_reg;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_valid_next = 1'b1;
                out_data_next  = res_data;
                out_user_next  = res_user;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_user_next  = res_user;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

>>> sv/fam_checker.sv
`default_nettype none

module fam_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [1:0]  cfg_index,
    input wire logic [6:0]  cfg_data
);

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Without a command byte there is no echo, no error and no shutter pulse.
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[11:4] == 8'd0 && !m_tdata[12] && !m_tdata[3])
        else $error("idle tick reported command activity");

    // The motor never drives both ways.
    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("motor driven forward and reverse");

    // A rejected byte does not fire the shutter.
    a_error_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> !m_tdata[3])
        else $error("shutter pulse on an unknown command");

endmodule

bind frame_advance_motor_controller fam_checker u_fam_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

import fam_pkg::*;

// Bit-accurate predictor for the frame advance controller. It keeps its own copy of
// the motion state, the IR integrator, the sensor history and the three registers,
// and queues one expected result for every tick that crosses the input channel.
class tick_predictor;
    logic [6:0] full_level;
    logic [3:0] single_frames;
    logic [3:0] multi_frames;

    logic [2:0] mode;
    logic [3:0] frames_left;
    logic [6:0] integ;
    logic [7:0] history;
    logic       lamp;

    fam_out_t   expected_ticks[$];
    int         errors;

    function new();
        full_level    = IR_FULL_RESET;
        single_frames = SINGLE_FRAMES_RESET;
        multi_frames  = MULTI_FRAMES_RESET;
        mode          = MODE_STOP;
        frames_left   = 4'd0;
        integ         = IR_START;
        history       = 8'h00;
        lamp          = 1'b0;
        errors        = 0;
    endfunction

    function int pending();
        return expected_ticks.size();
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [6:0] val);
        case (idx)
            CFG_IR_FULL_LEVEL:      full_level    = val;
            CFG_SINGLE_STEP_FRAMES: single_frames = val[3:0];
            CFG_MULTI_STEP_FRAMES:  multi_frames  = val[3:0];
            default: ;
        endcase
    endfunction

    function void accept_tick(input fam_in_t t);
        fam_out_t   res;
        logic       shutter;
        logic       err;
        logic       mark;
        shutter = 1'b0;
        err     = 1'b0;

        if (t.cmd_valid) begin
            case (t.cmd_byte)
                CHR_A_LO, CHR_A_UP: begin
                    mode = MODE_NEXT;
                    frames_left = single_frames;
                end
                CHR_B_LO, CHR_B_UP: begin
                    mode = MODE_PREV;
                    frames_left = single_frames;
                end
                CHR_N_LO, CHR_N_UP: begin
                    mode = MODE_NEXT;
                    frames_left = multi_frames;
                end
                CHR_P_LO, CHR_P_UP: begin
                    mode = MODE_PREV;
                    frames_left = multi_frames;
                end
                CHR_F_LO, CHR_F_UP: mode = MODE_FORWARD;
                CHR_R_LO, CHR_R_UP: mode = MODE_REVERSE;
                CHR_S_LO, CHR_S_UP: mode = MODE_STOP;
                CHR_X_LO, CHR_X_UP: begin
                    mode = MODE_STOP;
                    lamp = 1'b0;
                end
                CHR_L_LO: lamp = 1'b1;
                CHR_L_UP: lamp = 1'b0;
                CHR_C_LO, CHR_C_UP: shutter = 1'b1;
                CHR_LF, CHR_CR: ;
                default: err = 1'b1;
            endcase
        end

        // Up/down integrator; a value left above a lowered full level is clamped.
        if (t.ir_level) begin
            if (integ != 7'd0)
                integ = integ - 7'd1;
        end else if (integ < full_level) begin
            integ = integ + 7'd1;
        end else begin
            integ = full_level;
        end
        // With a full level of zero both rails hit, shifting a 0 and then a 1.
        if (integ == 7'd0)
            history = {history[6:0], 1'b0};
        if (integ == full_level)
            history = {history[6:0], 1'b1};

        mark = (history == FRAME_PATTERN);
        if (mark && (mode == MODE_NEXT || mode == MODE_PREV)) begin
            if (frames_left <= 4'd1) begin
                frames_left = 4'd0;
                mode = MODE_STOP;
            end else begin
                frames_left = frames_left - 4'd1;
            end
        end

        res.motor_forward = (mode == MODE_FORWARD || mode == MODE_NEXT);
        res.motor_reverse = (mode == MODE_REVERSE || mode == MODE_PREV);
        res.lamp_on       = lamp;
        res.shutter_pulse = shutter;
        res.echo_valid    = t.cmd_valid;
        res.echo_byte     = t.cmd_valid ? t.cmd_byte : 8'h00;
        res.command_error = err;
        res.ir_indicator  = t.ir_level;
        res.frame_mark    = mark;
        expected_ticks.push_back(res);
    endfunction

    function void compare_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(input fam_out_t got);
        fam_out_t exp_r;
        if (expected_ticks.size() == 0) begin
            $display("%0t: result with no tick outstanding, actual %0h", $time, got);
            errors++;
            return;
        end
        exp_r = expected_ticks.pop_front();
        compare_field("motor_forward", exp_r.motor_forward, got.motor_forward);
        compare_field("motor_reverse", exp_r.motor_reverse, got.motor_reverse);
        compare_field("lamp_on",       exp_r.lamp_on,       got.lamp_on);
        compare_field("shutter_pulse", exp_r.shutter_pulse, got.shutter_pulse);
        compare_field("echo_valid",    exp_r.echo_valid,    got.echo_valid);
        compare_field("echo_byte",     exp_r.echo_byte,     got.echo_byte);
        compare_field("command_error", exp_r.command_error, got.command_error);
        compare_field("ir_indicator",  exp_r.ir_indicator,  got.ir_indicator);
        compare_field("frame_mark",    exp_r.frame_mark,    got.frame_mark);
    endfunction
endclass

module testbench;

    // The limit covers both sides stalling at their maximum, plus the long receiver
    // hold-offs, and leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          PHASE_COUNT  = 12;
    localparam int          PHASE_TICKS  = 120;
    localparam int          HOLD_CYCLES  = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    tick_predictor sb = new();

    // Pacing controls for the sender and the receiver. A "steady" side runs
    // without gaps until it randomly flips back to drawing gaps per transfer.
    logic        tx_steady = 1'b0;
    logic        rx_steady = 1'b0;
    int          tx_burst_left = 0;
    int          rx_hold_request = 0;

    logic [7:0]  command_chars [22];

    frame_advance_motor_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Input monitor: every tick transfer is handed to the predictor exactly as it
    // crossed the channel, so the expected result follows the real stimulus.
    always @(posedge aclk) begin
        fam_in_t t;
        if (aresetn && s_tvalid && s_tready) begin
            t.cmd_valid = s_tuser[0];
            t.cmd_byte  = s_tdata[7:0];
            t.ir_level  = s_tdata[8];
            sb.accept_tick(t);
        end
    end

    // Result monitor: unpack the result transfer field by field and check it.
    always @(posedge aclk) begin
        fam_out_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.motor_forward = m_tdata[0];
            got.motor_reverse = m_tdata[1];
            got.lamp_on       = m_tdata[2];
            got.shutter_pulse = m_tdata[3];
            got.echo_byte     = m_tdata[11:4];
            got.command_error = m_tdata[12];
            got.ir_indicator  = m_tdata[13];
            got.frame_mark    = m_tdata[14];
            got.echo_valid    = m_tuser[0];
            sb.check_result(got);
        end
    end

    // Receiver: stalls a random number of cycles before each result, sometimes runs
    // flat out, and honors a long hold-off when the stimulus asks for one so that the
    // output buffer fills and the block has to stall its input.
    initial begin : receiver
        int unsigned stall;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (rx_hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_request) @(posedge aclk);
                rx_hold_request = 0;
            end
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offers one control tick and returns at the edge where it is transferred.
    // tvalid stays high into the next tick when no gap is drawn.
    task automatic send_tick(input logic has_cmd, input logic [7:0] cmd_char,
                             input logic ir);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        gap = (tx_steady || tx_burst_left > 0) ? 0 : $urandom_range(0, 17);
        if (tx_burst_left > 0)
            tx_burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, ir, cmd_char};
        s_tuser  <= has_cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering ticks and waits until every queued result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Writes all three registers back to back; only called while the block is idle.
    // The unused upper bits of the frame-count writes carry random values.
    task automatic set_config(input logic [6:0] level, input logic [3:0] single_n,
                              input logic [3:0] multi_n);
        logic [1:0] idx [3];
        logic [6:0] val [3];
        idx[0] = CFG_IR_FULL_LEVEL;
        idx[1] = CFG_SINGLE_STEP_FRAMES;
        idx[2] = CFG_MULTI_STEP_FRAMES;
        val[0] = level;
        val[1] = {3'($urandom_range(0, 7)), single_n};
        val[2] = {3'($urandom_range(0, 7)), multi_n};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random phase. Most ticks follow alternating beam/no-beam runs long enough to
    // drive the integrator rail to rail, which is what builds frame marks; the rest
    // is per-tick noise. Commands are sprinkled in, mostly known characters.
    task automatic run_phase(input int hold_at);
        int   run_left;
        logic run_ir;
        logic noisy;
        logic ir;
        logic has_cmd;
        logic [7:0] cmd_char;
        run_left = 0;
        run_ir   = 1'b1;
        noisy    = 1'b0;
        for (int i = 0; i < PHASE_TICKS; i++) begin
            if (run_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    noisy    = 1'b0;
                    run_ir   = !run_ir;
                    run_left = int'(sb.full_level) + $urandom_range(0, 6);
                    if (run_left == 0)
                        run_left = 1;
                end else begin
                    noisy    = 1'b1;
                    run_left = $urandom_range(1, 5);
                end
            end
            run_left--;
            ir = noisy ? 1'($urandom_range(0, 1)) : run_ir;

            has_cmd = ($urandom_range(0, 5) == 0);
            if (!has_cmd || $urandom_range(0, 4) == 0)
                cmd_char = 8'($urandom_range(0, 255));
            else
                cmd_char = command_chars[$urandom_range(0, 21)];

            if (i == hold_at) begin
                // Long receiver hold-off while the sender keeps offering ticks.
                rx_hold_request = HOLD_CYCLES;
                tx_burst_left   = 20;
            end
            send_tick(has_cmd, cmd_char, ir);
        end
    endtask

    initial begin : stimulus
        logic [6:0] level;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 16'd0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IR_FULL_LEVEL;
        cfg_data  = 7'd0;
        command_chars = '{CHR_A_LO, CHR_A_UP, CHR_B_LO, CHR_B_UP, CHR_N_LO, CHR_N_UP,
                          CHR_P_LO, CHR_P_UP, CHR_F_LO, CHR_F_UP, CHR_R_LO, CHR_R_UP,
                          CHR_S_LO, CHR_S_UP, CHR_X_LO, CHR_X_UP, CHR_L_LO, CHR_L_UP,
                          CHR_C_LO, CHR_C_UP, CHR_LF, CHR_CR};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sweep at the reset register values: every command character,
        // unknown bytes at both ends of the range, and an idle tick whose byte
        // must not be echoed.
        for (int i = 0; i < 22; i++)
            send_tick(1'b1, command_chars[i], 1'(i % 2));
        send_tick(1'b1, 8'h00, 1'b0);
        send_tick(1'b1, 8'hff, 1'b1);
        send_tick(1'b0, 8'ha5, 1'b0);
        drain_results();

        // Full level of zero with zero step counts: both rails coincide.
        set_config(7'd0, 4'd0, 4'd0);
        send_tick(1'b1, CHR_A_LO, 1'b0);
        send_tick(1'b0, 8'h5a, 1'b0);
        send_tick(1'b1, CHR_P_UP, 1'b1);
        drain_results();

        // Random phases. The first few settings hit the register extremes; the
        // top-level phase leaves the integrator high so the next, lowered level
        // starts with the integrator above the full level.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: set_config(7'd127, 4'd15, 4'd15);
                1: set_config(7'd1, 4'd1, 4'd1);
                2: set_config(7'd4, 4'd0, 4'd15);
                3: set_config(7'd0, 4'd15, 4'd0);
                4: set_config(7'd3, 4'd2, 4'd5);
                default: begin
                    level = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(1, 10));
                    set_config(level, 4'($urandom_range(0, 15)),
                               4'($urandom_range(0, 15)));
                end
            endcase
            run_phase((p == 2 || p == 7) ? 30 : -1);
            drain_results();
        end

        repeat (5) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Cycle budget for the whole run.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/fam_pkg.sv
sv/fam_core.sv
sv/frame_advance_motor_controller.sv
sv/fam_checker.sv
bench/testbench.sv
